// ===== hw/rtl/mlcd_pkg.sv =====
package mlcd_pkg;

    // Port access codes carried by the operation field.
    localparam logic [1:0] OP_STATUS_READ = 2'd0;
    localparam logic [1:0] OP_CMD_WRITE   = 2'd1;
    localparam logic [1:0] OP_DATA_READ   = 2'd2;
    localparam logic [1:0] OP_DATA_WRITE  = 2'd3;

    // Command prefix masks and match values.
    localparam logic [7:0] CMD_MASK_TOP2   = 8'hC0;
    localparam logic [7:0] CMD_CONTRAST    = 8'hC0;
    localparam logic [7:0] CMD_ROW         = 8'h80;
    localparam logic [7:0] CMD_SCROLL      = 8'h40;
    localparam logic [7:0] CMD_MASK_TOP3   = 8'hE0;
    localparam logic [7:0] CMD_PAGE        = 8'h20;
    localparam logic [7:0] CMD_MASK_AMP    = 8'h18;
    localparam logic [7:0] CMD_TEST_MODE   = 8'h18;
    localparam logic [7:0] CMD_AMP_ONE     = 8'h10;
    localparam logic [7:0] CMD_AMP_TWO     = 8'h08;
    localparam logic [7:0] CMD_COUNTER_BIT = 8'h04;
    localparam logic [7:0] CMD_DISPLAY_BIT = 8'h02;

    // Reset values of the mode flags.
    localparam logic RST_COUNT_UP   = 1'b1;
    localparam logic RST_EIGHT_BITS = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic setup;
        logic bit_step;
        logic out_load;
        logic apply_cmd;
        logic advance;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic bits_last;
        logic out_free;
        logic is_data;
    } dp_status_t;

    // Reduces x modulo m by comparing x with the multiples of m up to eight
    // times m side by side and subtracting the largest one that fits.
    // Callers keep x below nine times m, so that multiple always exists.
    function automatic logic [6:0] mod_reduce(input logic [6:0] x, input logic [6:0] m);
        logic [9:0] multiple;
        logic [6:0] r;
        r = x;
        for (int k = 1; k < 9; k++)
        begin
            multiple = 10'(k) * {3'b000, m};
            if ({3'b000, x} >= multiple)
            begin
                r = x - multiple[6:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mlcd_ctrl.sv =====
module mlcd_ctrl
    import mlcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_BITS   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Data accesses load the word address; others finish here.
                if (status.is_data)
                begin
                    cmd.setup  = 1'b1;
                    state_next = S_BITS;
                end
                else if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.apply_cmd = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_BITS:
            begin
                cmd.bit_step = 1'b1;
                if (status.bits_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.advance  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/mlcd_datapath.sv =====
module mlcd_datapath
    import mlcd_pkg::*;
#(
    parameter int ROWS    = 64,
    parameter int COLUMNS = 120
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] operation,
    input  logic [7:0] write_value,
    output logic [7:0] read_data,
    output logic       out_valid,
    input  logic       out_ready,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status
);

    localparam int MEM_DEPTH = ROWS * COLUMNS;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int PAGES8    = COLUMNS / 8;
    localparam int PAGES6    = COLUMNS / 6;
    // Wide enough for 63 * 120 plus the largest page base.
    localparam int SUM_W     = 14;

    logic             pixel_mem [MEM_DEPTH];
    logic             mem_rd_reg;
    logic             mem_we;
    logic             mem_wdata;

    logic [1:0]       op_reg;
    logic [7:0]       val_reg;
    logic [7:0]       result_reg, result_next;

    logic [5:0]       row_reg, row_next;
    logic [4:0]       page_reg, page_next;
    logic [5:0]       scroll_reg, scroll_next;
    logic [5:0]       contrast_reg, contrast_next;
    logic [1:0]       amp_one_reg, amp_one_next;
    logic [1:0]       amp_two_reg, amp_two_next;
    logic             step_cols_reg, step_cols_next;
    logic             count_up_reg, count_up_next;
    logic             display_reg, display_next;
    logic             eight_reg, eight_next;

    logic [AW-1:0]    addr_reg, addr_next;
    logic [7:0]       col_reg, col_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             rd_ok_reg, rd_ok_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       read_data_reg, read_data_next;

    logic [7:0]       base;
    logic [SUM_W-1:0] addr_full;
    logic [4:0]       pages;
    logic             in_range;
    logic [2:0]       last_idx;
    logic [2:0]       wr_idx;
    logic [7:0]       status_byte;

    assign base      = eight_reg ? {page_reg, 3'b000}
                                 : ({1'b0, page_reg, 2'b00} + {2'b00, page_reg, 1'b0});
    assign addr_full = SUM_W'(row_reg) * SUM_W'(COLUMNS) + SUM_W'(base);
    assign pages     = eight_reg ? 5'(PAGES8) : 5'(PAGES6);
    assign in_range  = (7'(row_reg) < 7'(ROWS)) && (col_reg < 8'(COLUMNS));
    assign last_idx  = eight_reg ? 3'd7 : 3'd5;
    assign wr_idx    = last_idx - cnt_reg;

    assign status_byte = {1'b0, eight_reg, display_reg, 3'b000, step_cols_reg, count_up_reg};

    assign mem_we    = cmd.clear_step || (cmd.bit_step && (op_reg == OP_DATA_WRITE) && in_range);
    assign mem_wdata = cmd.clear_step ? 1'b0 : val_reg[wr_idx];

    assign status.clear_last = (addr_reg == AW'(MEM_DEPTH - 1));
    assign status.bits_last  = (cnt_reg == last_idx);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.is_data    = (op_reg == OP_DATA_READ) || (op_reg == OP_DATA_WRITE);

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    always_comb
    begin
        row_next       = row_reg;
        page_next      = page_reg;
        scroll_next    = scroll_reg;
        contrast_next  = contrast_reg;
        amp_one_next   = amp_one_reg;
        amp_two_next   = amp_two_reg;
        step_cols_next = step_cols_reg;
        count_up_next  = count_up_reg;
        display_next   = display_reg;
        eight_next     = eight_reg;
        addr_next      = addr_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        result_next    = result_reg;
        read_data_next = read_data_reg;

        if (cmd.apply_cmd && (op_reg == OP_CMD_WRITE))
        begin
            priority if ((val_reg & CMD_MASK_TOP2) == CMD_CONTRAST)
            begin
                contrast_next = val_reg[5:0];
            end
            else if ((val_reg & CMD_MASK_TOP2) == CMD_ROW)
            begin
                row_next = val_reg[5:0];
            end
            else if ((val_reg & CMD_MASK_TOP2) == CMD_SCROLL)
            begin
                scroll_next = val_reg[5:0];
            end
            else if ((val_reg & CMD_MASK_TOP3) == CMD_PAGE)
            begin
                page_next = val_reg[4:0];
            end
            else if ((val_reg & CMD_MASK_AMP) == CMD_TEST_MODE)
            begin
                contrast_next = contrast_reg;
            end
            else if ((val_reg & CMD_MASK_AMP) == CMD_AMP_ONE)
            begin
                amp_one_next = val_reg[1:0];
            end
            else if ((val_reg & CMD_MASK_AMP) == CMD_AMP_TWO)
            begin
                amp_two_next = val_reg[1:0];
            end
            else if ((val_reg & CMD_COUNTER_BIT) != 8'h00)
            begin
                step_cols_next = val_reg[1];
                count_up_next  = val_reg[0];
            end
            else if ((val_reg & CMD_DISPLAY_BIT) != 8'h00)
            begin
                display_next = val_reg[0];
            end
            else
            begin
                eight_next = val_reg[0];
            end
        end

        // Pointer advance after a data access.
        if (cmd.advance)
        begin
            if (step_cols_reg)
            begin
                if (count_up_reg)
                begin
                    page_next = 5'(mod_reduce(7'(page_reg) + 7'd1, 7'(pages)));
                end
                else
                begin
                    page_next = (page_reg == 5'd0) ? (pages - 5'd1) : (page_reg - 5'd1);
                end
            end
            else
            begin
                if (count_up_reg)
                begin
                    row_next = 6'(mod_reduce(7'(row_reg) + 7'd1, 7'(ROWS)));
                end
                else
                begin
                    row_next = (row_reg == 6'd0) ? 6'(ROWS - 1) : (row_reg - 6'd1);
                end
            end
        end

        if (cmd.clear_step)
        begin
            addr_next = addr_reg + AW'(1);
        end
        if (cmd.setup)
        begin
            addr_next   = AW'(addr_full);
            col_next    = base;
            cnt_next    = 3'd0;
            result_next = 8'h00;
        end
        if (cmd.bit_step)
        begin
            addr_next = addr_reg + AW'(1);
            col_next  = col_reg + 8'd1;
            cnt_next  = cnt_reg + 3'd1;
        end

        // Read bits arrive in the cycle after their address and shift in.
        if (rd_pend_reg)
        begin
            result_next = {result_reg[6:0], rd_ok_reg & mem_rd_reg};
        end

        rd_pend_next   = cmd.bit_step && (op_reg == OP_DATA_READ);
        rd_ok_next     = cmd.bit_step && in_range;
        out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);

        if (cmd.out_load)
        begin
            unique case (op_reg)
                OP_STATUS_READ: read_data_next = status_byte;
                OP_DATA_READ:   read_data_next = result_reg;
                OP_CMD_WRITE:   read_data_next = 8'h00;
                OP_DATA_WRITE:  read_data_next = 8'h00;
                default:        read_data_next = 8'h00;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pixel_mem[addr_reg] <= mem_wdata;
        end
        mem_rd_reg <= pixel_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= operation;
            val_reg <= write_value;
        end
        result_reg    <= result_next;
        read_data_reg <= read_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= 6'd0;
            page_reg      <= 5'd0;
            scroll_reg    <= 6'd0;
            contrast_reg  <= 6'd0;
            amp_one_reg   <= 2'd0;
            amp_two_reg   <= 2'd0;
            step_cols_reg <= 1'b0;
            count_up_reg  <= RST_COUNT_UP;
            display_reg   <= 1'b0;
            eight_reg     <= RST_EIGHT_BITS;
            addr_reg      <= '0;
            col_reg       <= 8'd0;
            cnt_reg       <= 3'd0;
            rd_pend_reg   <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            page_reg      <= page_next;
            scroll_reg    <= scroll_next;
            contrast_reg  <= contrast_next;
            amp_one_reg   <= amp_one_next;
            amp_two_reg   <= amp_two_next;
            step_cols_reg <= step_cols_next;
            count_up_reg  <= count_up_next;
            display_reg   <= display_next;
            eight_reg     <= eight_next;
            addr_reg      <= addr_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/mono_lcd_controller_core.sv =====
// Channel   Direction  Handshake            Payload
// --------  ---------  -------------------  ---------------------------
// input     in         in_valid / in_ready  operation, write_value
// output    out        out_valid / out_ready read_data
//
// A status read or command write goes from acceptance through the execute state
// to the output register. A data access steps through the W pixels of its word
// (8 or 6) on the one-bit pixel memory port, which visits one pixel per cycle.
// After reset the pixel memory is cleared one bit per cycle, all ROWS * COLUMNS
// bits (7680 at the defaults), while in_ready stays low.
// A stalled output holds its result; the controller waits before finishing
// the next transaction, and one further transaction can still be accepted.
module mono_lcd_controller_core
    import mlcd_pkg::*;
#(
    parameter int ROWS    = 64,
    parameter int COLUMNS = 120
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] write_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data
);

    // The controller sequences each transaction; the datapath owns the pixel
    // memory, the pointers and mode flags, and the output register.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    mlcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mlcd_datapath #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .write_value (write_value),
        .read_data   (read_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mlcd_pkg::*;

    localparam int ROWS         = 64;
    localparam int COLUMNS      = 120;
    localparam int RANDOM_ITEMS = 1800;
    // The pixel clear after reset runs with no transaction, and the long
    // output hold-off adds to that idle time.
    localparam int IDLE_LIMIT   = 40000;
    localparam int HOLD_START   = 12000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 32;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_ALTERNATE} rx_mode_t;

    // One row of the directed stimulus. Where pinned is set, the read data
    // is known by inspection and is checked as typed in.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] value;
        logic       pinned;
        logic [7:0] pinned_data;
    } lcd_vector_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [1:0] operation   = OP_STATUS_READ;
    logic [7:0] write_value = 8'h00;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] read_data;

    // Shadow copy of the controller state.
    bit         pixel_store [ROWS * COLUMNS];
    logic [5:0] row_ptr;
    logic [4:0] col_page;
    logic [5:0] scroll_row;
    logic [5:0] contrast;
    logic [1:0] amp_one;
    logic [1:0] amp_two;
    logic       step_cols;
    logic       cnt_up;
    logic       disp_on;
    logic       wide_words;

    logic [7:0] read_data_queue [$];
    logic [7:0] expected_data;
    int         fail_count = 0;
    int         burst_left = 0;
    int         idle_cycles = 0;
    int         rx_cycle = 0;
    int         rx_hold_left = 0;
    int         rx_mode_left = 0;
    rx_mode_t   rx_mode = RX_STEADY;

    lcd_vector_t directed_vectors [0:27] = '{
        '{OP_STATUS_READ, 8'h00, 1'b1, 8'h41},
        '{OP_DATA_READ,   8'h00, 1'b1, 8'h00},
        '{OP_DATA_WRITE,  8'hFF, 1'b1, 8'h00},
        '{OP_CMD_WRITE,   CMD_CONTRAST | 8'h3F, 1'b1, 8'h00},
        '{OP_CMD_WRITE,   CMD_ROW | 8'h01, 1'b0, 8'h00},
        '{OP_DATA_READ,   8'h00, 1'b1, 8'hFF},
        '{OP_CMD_WRITE,   CMD_SCROLL | 8'h3F, 1'b0, 8'h00},
        '{OP_CMD_WRITE,   CMD_ROW | 8'h3F, 1'b0, 8'h00},
        '{OP_DATA_WRITE,  8'h00, 1'b1, 8'h00},
        '{OP_CMD_WRITE,   CMD_PAGE | 8'h1F, 1'b0, 8'h00},
        '{OP_DATA_WRITE,  8'hA5, 1'b1, 8'h00},
        '{OP_CMD_WRITE,   CMD_TEST_MODE | 8'h07, 1'b0, 8'h00},
        '{OP_CMD_WRITE,   CMD_AMP_ONE | 8'h03, 1'b0, 8'h00},
        '{OP_CMD_WRITE,   CMD_AMP_TWO | 8'h03, 1'b0, 8'h00},
        '{OP_CMD_WRITE,   CMD_COUNTER_BIT | 8'h03, 1'b0, 8'h00},
        '{OP_CMD_WRITE,   CMD_PAGE | 8'h0E, 1'b0, 8'h00},
        '{OP_DATA_WRITE,  8'h5A, 1'b0, 8'h00},
        '{OP_CMD_WRITE,   CMD_DISPLAY_BIT | 8'h01, 1'b0, 8'h00},
        '{OP_CMD_WRITE,   8'h00, 1'b1, 8'h00},
        '{OP_CMD_WRITE,   CMD_COUNTER_BIT | 8'h02, 1'b0, 8'h00},
        '{OP_DATA_READ,   8'h00, 1'b1, 8'h3F},
        '{OP_DATA_WRITE,  8'h2A, 1'b0, 8'h00},
        '{OP_STATUS_READ, 8'hFF, 1'b1, 8'h22},
        '{OP_CMD_WRITE,   CMD_COUNTER_BIT, 1'b0, 8'h00},
        '{OP_CMD_WRITE,   CMD_ROW, 1'b0, 8'h00},
        '{OP_DATA_READ,   8'h00, 1'b1, 8'h00},
        '{OP_CMD_WRITE,   8'h01, 1'b0, 8'h00},
        '{OP_CMD_WRITE,   CMD_DISPLAY_BIT, 1'b0, 8'h00}
    };

    mono_lcd_controller_core #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data)
    );

    always #6 clk = ~clk;

    function automatic void lcd_state_reset();
        int k;
        for (k = 0; k < ROWS * COLUMNS; k++)
        begin
            pixel_store[k] = 1'b0;
        end
        row_ptr    = '0;
        col_page   = '0;
        scroll_row = '0;
        contrast   = '0;
        amp_one    = '0;
        amp_two    = '0;
        step_cols  = 1'b0;
        cnt_up     = 1'b1;
        disp_on    = 1'b0;
        wide_words = 1'b1;
    endfunction

    // Moves the row or the column page by one after a data access.
    function automatic void step_pointer();
        int pages;
        if (step_cols)
        begin
            pages = wide_words ? COLUMNS / 8 : COLUMNS / 6;
            if (cnt_up)
                col_page = 5'((int'(col_page) + 1) % pages);
            else
                col_page = (col_page == 0) ? 5'(pages - 1) : col_page - 5'd1;
        end
        else
        begin
            if (cnt_up)
                row_ptr = 6'((int'(row_ptr) + 1) % ROWS);
            else
                row_ptr = (row_ptr == 0) ? 6'(ROWS - 1) : row_ptr - 6'd1;
        end
    endfunction

    // Applies one port access to the shadow state and returns the read data.
    function automatic logic [7:0] lcd_access(input logic [1:0] op, input logic [7:0] value);
        int         width;
        int         base;
        int         col;
        int         i;
        logic [7:0] word;
        width = wide_words ? 8 : 6;
        base  = int'(col_page) * width;
        word  = '0;
        case (op)
            OP_STATUS_READ:
                word = {1'b0, wide_words, disp_on, 3'b000, step_cols, cnt_up};
            OP_CMD_WRITE:
            begin
                if ((value & CMD_MASK_TOP2) == CMD_CONTRAST)
                    contrast = value[5:0];
                else if ((value & CMD_MASK_TOP2) == CMD_ROW)
                    row_ptr = value[5:0];
                else if ((value & CMD_MASK_TOP2) == CMD_SCROLL)
                    scroll_row = value[5:0];
                else if ((value & CMD_MASK_TOP3) == CMD_PAGE)
                    col_page = value[4:0];
                else if ((value & CMD_MASK_AMP) == CMD_TEST_MODE)
                begin
                    // Test mode changes nothing.
                end
                else if ((value & CMD_MASK_AMP) == CMD_AMP_ONE)
                    amp_one = value[1:0];
                else if ((value & CMD_MASK_AMP) == CMD_AMP_TWO)
                    amp_two = value[1:0];
                else if ((value & CMD_COUNTER_BIT) != 0)
                begin
                    step_cols = value[1];
                    cnt_up    = value[0];
                end
                else if ((value & CMD_DISPLAY_BIT) != 0)
                    disp_on = value[0];
                else
                    wide_words = value[0];
            end
            OP_DATA_READ:
            begin
                // Columns past the right edge read as zero.
                for (i = 0; i < width; i++)
                begin
                    col  = base + i;
                    word = {word[6:0], (row_ptr < ROWS && col < COLUMNS) ?
                            pixel_store[int'(row_ptr) * COLUMNS + col] : 1'b0};
                end
                step_pointer();
            end
            default:
            begin
                for (i = 0; i < width; i++)
                begin
                    col = base + i;
                    if (row_ptr < ROWS && col < COLUMNS)
                        pixel_store[int'(row_ptr) * COLUMNS + col] = value[width - 1 - i];
                end
                step_pointer();
            end
        endcase
        return word;
    endfunction

    // Offers one transaction, with a random gap at the start of each burst,
    // and records the expected read data once it is accepted.
    task automatic offer_access(input logic [1:0] op, input logic [7:0] value,
                                input logic pinned, input logic [7:0] pinned_data);
        int         gap;
        logic [7:0] predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        operation   <= op;
        write_value <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = lcd_access(op, value);
        read_data_queue.push_back(pinned ? pinned_data : predicted);
    endtask

    initial
    begin
        int         n;
        int         pick;
        logic [1:0] op;
        logic [7:0] value;
        lcd_state_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < $size(directed_vectors); n++)
        begin
            offer_access(directed_vectors[n].op, directed_vectors[n].value,
                         directed_vectors[n].pinned, directed_vectors[n].pinned_data);
        end

        // Mostly data accesses; command bytes are built per family so that
        // every decode path is taken, with row and page kept small most of
        // the time so that reads land on pixels written earlier.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick  = $urandom_range(0, 99);
            value = 8'($urandom);
            if (pick < 8)
                op = OP_STATUS_READ;
            else if (pick < 36)
            begin
                op = OP_CMD_WRITE;
                case ($urandom_range(0, 10))
                    0: value = CMD_CONTRAST | 8'($urandom_range(0, 63));
                    1: value = CMD_ROW | 8'(($urandom_range(0, 3) == 0) ?
                               $urandom_range(0, 63) : $urandom_range(0, 7));
                    2: value = CMD_SCROLL | 8'($urandom_range(0, 63));
                    3: value = CMD_PAGE | 8'(($urandom_range(0, 7) == 0) ?
                               $urandom_range(0, 31) : $urandom_range(0, 19));
                    4: value = CMD_TEST_MODE | 8'($urandom_range(0, 7));
                    5: value = CMD_AMP_ONE | 8'($urandom_range(0, 7));
                    6: value = CMD_AMP_TWO | 8'($urandom_range(0, 7));
                    7: value = CMD_COUNTER_BIT | 8'($urandom_range(0, 3));
                    8: value = CMD_DISPLAY_BIT | 8'($urandom_range(0, 1));
                    9: value = 8'($urandom_range(0, 1));
                    default: value = 8'($urandom);
                endcase
            end
            else if (pick < 68)
                op = OP_DATA_READ;
            else
                op = OP_DATA_WRITE;
            offer_access(op, value, 1'b0, 8'h00);
        end
        in_valid <= 1'b0;

        while (read_data_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: a new stall pattern every so often, plus one long hold-off
    // that lets the controller fill up and push back on its input.
    always @(posedge clk)
    begin
        if (rst_n)
            rx_cycle++;
        if (rx_cycle == HOLD_START)
            rx_hold_left = HOLD_CYCLES;
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 200);
        end
        rx_mode_left--;
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_STEADY:   out_ready <= 1'b1;
                RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
                default:     out_ready <= rx_cycle[0];
            endcase
        end
    end

    // Compares each output transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (read_data_queue.size() == 0)
            begin
                $display("%0t: read_data %02h with no transaction pending", $time, read_data);
                fail_count++;
            end
            else
            begin
                expected_data = read_data_queue.pop_front();
                if (read_data !== expected_data)
                begin
                    $display("%0t: read_data expected %02h actual %02h",
                             $time, expected_data, read_data);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

// ===== mono_lcd_controller_core.f =====
hw/rtl/mlcd_pkg.sv
hw/rtl/mlcd_ctrl.sv
hw/rtl/mlcd_datapath.sv
hw/rtl/mono_lcd_controller_core.sv
verif/testbench.sv
